FILE: hdl/atsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt angle smoother package
// Shared widths, fixed-point constants, the arctangent table, the clamp helper
// and the structs that connect the sequencer to the CORDIC unit.
// ----------------------------------------------------------------------------
package atsm_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int TAB_LEN      = 24;
	localparam int N_STEPS      = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
	localparam int CNT_W        = $clog2(N_STEPS);
	localparam int TAB_IDX_W    = $clog2(TAB_LEN);

	localparam int VEC_W  = 34;
	localparam int ANG_W  = 28;
	localparam int FILT_W = 26;
	localparam int MAG_W  = 31;
	localparam int ALPHA_W = 17;
	localparam int VEC_SHIFT = 14;

	localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(180 * 131072);
	localparam logic signed [ANG_W-1:0] ANG_90  = ANG_W'(90 * 131072);
	localparam logic [29:0] GAIN_Q30 = 30'd652032874;
	localparam logic [ALPHA_W-1:0] ALPHA_MAX   = 17'd65536;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd13107;

	typedef struct packed {
		logic                    start;
		logic signed [VEC_W-1:0] a;
		logic signed [VEC_W-1:0] b;
		logic signed [ANG_W-1:0] ang;
	} cordic_cmd_t;

	typedef struct packed {
		logic                    done;
		logic signed [VEC_W-1:0] mag;
		logic signed [ANG_W-1:0] ang;
	} cordic_rsp_t;

	function automatic logic signed [ANG_W-1:0] atan_deg(input logic [TAB_IDX_W-1:0] idx);
		logic signed [ANG_W-1:0] r;
		case (idx)
			5'd0:    r = 28'sd5898240;
			5'd1:    r = 28'sd3481934;
			5'd2:    r = 28'sd1839759;
			5'd3:    r = 28'sd933890;
			5'd4:    r = 28'sd468757;
			5'd5:    r = 28'sd234607;
			5'd6:    r = 28'sd117332;
			5'd7:    r = 28'sd58670;
			5'd8:    r = 28'sd29335;
			5'd9:    r = 28'sd14668;
			5'd10:   r = 28'sd7334;
			5'd11:   r = 28'sd3667;
			5'd12:   r = 28'sd1833;
			5'd13:   r = 28'sd917;
			5'd14:   r = 28'sd458;
			5'd15:   r = 28'sd229;
			5'd16:   r = 28'sd115;
			5'd17:   r = 28'sd57;
			5'd18:   r = 28'sd29;
			5'd19:   r = 28'sd14;
			5'd20:   r = 28'sd7;
			5'd21:   r = 28'sd4;
			5'd22:   r = 28'sd2;
			5'd23:   r = 28'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [FILT_W-1:0] clamp_ang(
		input logic signed [ANG_W-1:0] v,
		input logic signed [ANG_W-1:0] lim
	);
		logic signed [ANG_W-1:0] r;
		if (v > lim) begin
			r = lim;
		end else if (v < -lim) begin
			r = -lim;
		end else begin
			r = v;
		end
		return r[FILT_W-1:0];
	endfunction

endpackage

FILE: hdl/accel_tilt_angle_smoother_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accelerometer tilt angle smoother
// Computes roll and pitch from one accelerometer sample with an iterative
// CORDIC unit and smooths both with an exponential moving average.
//
// Usage:
//   The input channel (in_valid / in_ready) carries one sample, accel_x,
//   accel_y and accel_z. The output channel (out_valid / out_ready) returns
//   tilt_x (roll, signed Q9.8) and tilt_y (pitch, signed Q8.8) in degrees,
//   one result per sample. The configuration channel (cfg_valid / cfg_ready)
//   writes the smoothing factor; values above 65536 saturate to 65536.
//   A sample runs two CORDIC vectoring passes of 16 steps each on the one
//   shift-add unit: the roll pass result is taken, the gain multiply is
//   applied, the pitch pass is started and its result taken, each filter is
//   updated in turn and the output register is loaded. A sample with y and z
//   both zero skips the roll pass. The block takes a new sample only after
//   the last one is through the filter: in_ready is high only when idle and
//   no finished result waits to be loaded into the output register.
//   A finished result waits in the output register; the next sample is taken
//   meanwhile and only its own result waits for that register to empty.
//   Reset clears the filter, so the first sample after reset loads it
//   directly, and sets the smoothing factor to 13107.
// ----------------------------------------------------------------------------
module accel_tilt_angle_smoother_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [16:0] tilt_x,
	output logic signed [15:0] tilt_y,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [16:0]        cfg_data
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_ROLL  = 7'b0000010,
		S_GAIN  = 7'b0000100,
		S_PREP  = 7'b0001000,
		S_PITCH = 7'b0010000,
		S_EMA_R = 7'b0100000,
		S_EMA_P = 7'b1000000
	} state_t;

	state_t state_q;
	logic   done_wait_q;

	logic [atsm_pkg::ALPHA_W-1:0]       alpha_q;
	logic signed [15:0]                 ax_q;
	logic signed [atsm_pkg::VEC_W-1:0]  raw_q;
	logic [atsm_pkg::MAG_W-1:0]         mag_q;
	logic signed [atsm_pkg::FILT_W-1:0] roll_q;
	logic signed [atsm_pkg::FILT_W-1:0] pitch_q;
	logic signed [atsm_pkg::FILT_W-1:0] froll_q;
	logic signed [atsm_pkg::FILT_W-1:0] fpitch_q;
	logic                               have_q;
	logic                               out_valid_q;
	logic signed [16:0]                 tilt_x_q;
	logic signed [15:0]                 tilt_y_q;

	atsm_pkg::cordic_cmd_t cmd;
	atsm_pkg::cordic_rsp_t rsp;

	logic                               in_xfer;
	logic                               yz_zero;
	logic                               pitch_run;
	logic                               out_load;
	logic signed [atsm_pkg::VEC_W-1:0]  ay_v;
	logic signed [atsm_pkg::VEC_W-1:0]  az_v;
	logic signed [atsm_pkg::VEC_W-1:0]  ax_v;
	logic [60:0]                        gain_prod;
	logic signed [atsm_pkg::FILT_W-1:0] ema_f;
	logic signed [atsm_pkg::FILT_W-1:0] ema_n;
	logic signed [atsm_pkg::FILT_W-1:0] ema_next;
	logic signed [atsm_pkg::FILT_W:0]   round_x;
	logic signed [atsm_pkg::FILT_W:0]   round_y;

	assign in_ready  = (state_q == S_IDLE) && !done_wait_q;
	assign in_xfer   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_load  = done_wait_q && (!out_valid_q || out_ready);

	assign yz_zero   = (accel_y == 16'sd0) && (accel_z == 16'sd0);
	assign pitch_run = (mag_q != '0) || (ax_q != 16'sd0);
	assign ay_v      = atsm_pkg::VEC_W'(accel_y) <<< atsm_pkg::VEC_SHIFT;
	assign az_v      = atsm_pkg::VEC_W'(accel_z) <<< atsm_pkg::VEC_SHIFT;
	assign ax_v      = atsm_pkg::VEC_W'(ax_q) <<< atsm_pkg::VEC_SHIFT;
	assign gain_prod = 61'(raw_q[atsm_pkg::MAG_W-1:0]) * 61'(atsm_pkg::GAIN_Q30);

	always_comb begin
		cmd = '0;
		if (in_xfer && !yz_zero) begin
			cmd.start = 1'b1;
			if (accel_z[15]) begin
				cmd.a   = -az_v;
				cmd.b   = -ay_v;
				cmd.ang = accel_y[15] ? -atsm_pkg::ANG_180 : atsm_pkg::ANG_180;
			end else begin
				cmd.a   = az_v;
				cmd.b   = ay_v;
				cmd.ang = '0;
			end
		end else if (state_q == S_PREP && pitch_run) begin
			cmd.start = 1'b1;
			cmd.a     = atsm_pkg::VEC_W'(mag_q);
			cmd.b     = -ax_v;
			cmd.ang   = '0;
		end
	end

	atsm_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	assign ema_f = (state_q == S_EMA_P) ? fpitch_q : froll_q;
	assign ema_n = (state_q == S_EMA_P) ? pitch_q : roll_q;

	atsm_ema u_ema (
		.filt      (ema_f),
		.sample    (ema_n),
		.alpha     (alpha_q),
		.filt_next (ema_next)
	);

	assign round_x = (atsm_pkg::FILT_W + 1)'(froll_q) + 27'sd256;
	assign round_y = (atsm_pkg::FILT_W + 1)'(fpitch_q) + 27'sd256;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			done_wait_q <= 1'b0;
			alpha_q     <= atsm_pkg::ALPHA_RESET;
			froll_q     <= '0;
			fpitch_q    <= '0;
			have_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				alpha_q <= (cfg_data > atsm_pkg::ALPHA_MAX) ? atsm_pkg::ALPHA_MAX : cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				done_wait_q <= 1'b0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= yz_zero ? S_PREP : S_ROLL;
					end
				end
				S_ROLL: begin
					if (rsp.done) begin
						state_q <= S_GAIN;
					end
				end
				S_GAIN: begin
					state_q <= S_PREP;
				end
				S_PREP: begin
					state_q <= pitch_run ? S_PITCH : S_EMA_R;
				end
				S_PITCH: begin
					if (rsp.done) begin
						state_q <= S_EMA_R;
					end
				end
				S_EMA_R: begin
					froll_q <= have_q ? ema_next : roll_q;
					state_q <= S_EMA_P;
				end
				S_EMA_P: begin
					fpitch_q    <= have_q ? ema_next : pitch_q;
					have_q      <= 1'b1;
					done_wait_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ax_q <= accel_x;
			if (yz_zero) begin
				roll_q <= '0;
				mag_q  <= '0;
			end
		end
		if (state_q == S_ROLL && rsp.done) begin
			roll_q <= atsm_pkg::clamp_ang(rsp.ang, atsm_pkg::ANG_180);
			raw_q  <= rsp.mag;
		end
		if (state_q == S_GAIN) begin
			mag_q <= gain_prod[60:30];
		end
		if (state_q == S_PREP && !pitch_run) begin
			pitch_q <= '0;
		end
		if (state_q == S_PITCH && rsp.done) begin
			pitch_q <= atsm_pkg::clamp_ang(rsp.ang, atsm_pkg::ANG_90);
		end
		if (out_load) begin
			tilt_x_q <= round_x[25:9];
			tilt_y_q <= round_y[24:9];
		end
	end

	assign out_valid = out_valid_q;
	assign tilt_x    = tilt_x_q;
	assign tilt_y    = tilt_y_q;

endmodule

FILE: hdl/atsm_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative CORDIC vectoring unit
// One shift-add rotation per cycle on a single shared datapath, driven by a
// step counter. Returns the raw magnitude and the accumulated angle.
// ----------------------------------------------------------------------------
module atsm_cordic (
	input  logic                 clk,
	input  logic                 arst_n,
	input  atsm_pkg::cordic_cmd_t cmd,
	output atsm_pkg::cordic_rsp_t rsp
);

	logic signed [atsm_pkg::VEC_W-1:0] a_q;
	logic signed [atsm_pkg::VEC_W-1:0] b_q;
	logic signed [atsm_pkg::ANG_W-1:0] ang_q;
	logic [atsm_pkg::CNT_W-1:0]        cnt_q;
	logic                              busy_q;
	logic                              done_q;

	logic signed [atsm_pkg::VEC_W-1:0] da;
	logic signed [atsm_pkg::VEC_W-1:0] db;
	logic signed [atsm_pkg::ANG_W-1:0] step_ang;

	assign da       = b_q >>> cnt_q;
	assign db       = a_q >>> cnt_q;
	assign step_ang = atsm_pkg::atan_deg(atsm_pkg::TAB_IDX_W'(cnt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == atsm_pkg::CNT_W'(atsm_pkg::N_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q   <= cmd.a;
			b_q   <= cmd.b;
			ang_q <= cmd.ang;
		end else if (busy_q) begin
			if (!b_q[atsm_pkg::VEC_W-1]) begin
				a_q   <= a_q + da;
				b_q   <= b_q - db;
				ang_q <= ang_q + step_ang;
			end else begin
				a_q   <= a_q - da;
				b_q   <= b_q + db;
				ang_q <= ang_q - step_ang;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.mag  = a_q;
	assign rsp.ang  = ang_q;

endmodule

FILE: hdl/atsm_ema.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exponential moving average update
// Moves a filtered angle toward a new angle by alpha/65536 of the difference,
// rounded to nearest. One multiplier, shared by the roll and pitch updates.
// ----------------------------------------------------------------------------
module atsm_ema (
	input  logic signed [atsm_pkg::FILT_W-1:0] filt,
	input  logic signed [atsm_pkg::FILT_W-1:0] sample,
	input  logic [atsm_pkg::ALPHA_W-1:0]       alpha,
	output logic signed [atsm_pkg::FILT_W-1:0] filt_next
);

	localparam int D_W = atsm_pkg::FILT_W + 1;
	localparam int A_W = atsm_pkg::ALPHA_W + 1;
	localparam int P_W = D_W + A_W;

	logic signed [D_W-1:0] diff;
	logic signed [A_W-1:0] alpha_s;
	logic signed [P_W-1:0] prod;
	logic signed [P_W-1:0] rounded;
	logic signed [P_W-1:0] upd;

	always_comb begin
		diff      = D_W'(sample) - D_W'(filt);
		alpha_s   = $signed({1'b0, alpha});
		prod      = P_W'(diff) * P_W'(alpha_s);
		rounded   = prod + P_W'(32768);
		upd       = rounded >>> 16;
		filt_next = filt + upd[atsm_pkg::FILT_W-1:0];
	end

endmodule

FILE: sim/tilt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt angle smoother checker
// Watches the sample, result and weight channels of the tilt smoother. For
// every sample transfer it computes the roll and pitch that the block must
// return, using CORDIC vectoring and the moving-average filter, and queues
// them. Every result transfer is compared field by field with the oldest
// queued result. Mismatches, the number of results still owed and the number
// of results compared are passed to the testbench top.
// ----------------------------------------------------------------------------
module tilt_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [16:0] tilt_x,
	input  logic signed [15:0] tilt_y,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [16:0]        cfg_data,
	output int                 mismatches,
	output int                 pending,
	output int                 checked
);

	localparam int STEPS = (atsm_pkg::CORDIC_STEPS < 24) ? atsm_pkg::CORDIC_STEPS : 24;
	localparam longint DEG_ONE = 131072;
	localparam longint HALF_TURN = 180 * DEG_ONE;
	localparam longint QUARTER_TURN = 90 * DEG_ONE;
	localparam longint GAIN_FIX = 652032874;
	localparam longint VEC_ONE = 16384;

	typedef struct packed {
		logic signed [16:0] roll;
		logic signed [15:0] pitch;
	} tilt_t;

	tilt_t              expected_tilts[$];
	logic signed [25:0] roll_f;
	logic signed [25:0] pitch_f;
	bit                 primed;
	logic [16:0]        weight;

	function automatic longint arctan_deg(input int i);
		case (i)
			0:       return 5898240;
			1:       return 3481934;
			2:       return 1839759;
			3:       return 933890;
			4:       return 468757;
			5:       return 234607;
			6:       return 117332;
			7:       return 58670;
			8:       return 29335;
			9:       return 14668;
			10:      return 7334;
			11:      return 3667;
			12:      return 1833;
			13:      return 917;
			14:      return 458;
			15:      return 229;
			16:      return 115;
			17:      return 57;
			18:      return 29;
			19:      return 14;
			20:      return 7;
			21:      return 4;
			22:      return 2;
			23:      return 1;
			default: return 0;
		endcase
	endfunction

	function automatic longint cordic_vector(input longint x0, input longint y0,
			output longint radius);
		longint x;
		longint y;
		longint dx;
		longint dy;
		longint ang;
		x = x0;
		y = y0;
		ang = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				ang = ang + arctan_deg(i);
			end else begin
				x = x - dx;
				y = y + dy;
				ang = ang - arctan_deg(i);
			end
		end
		radius = x;
		return ang;
	endfunction

	function automatic longint limit_angle(input longint v, input longint lim);
		if (v > lim) begin
			return lim;
		end
		if (v < -lim) begin
			return -lim;
		end
		return v;
	endfunction

	function automatic longint smooth(input longint f, input longint n);
		return f + (((n - f) * longint'(weight) + 32768) >>> 16);
	endfunction

	function automatic tilt_t predict_tilt(input logic signed [15:0] ax,
			input logic signed [15:0] ay, input logic signed [15:0] az);
		longint x;
		longint y;
		longint z;
		longint a;
		longint b;
		longint base;
		longint roll;
		longint pitch;
		longint mag;
		longint raw;
		tilt_t  r;
		x = longint'(ax);
		y = longint'(ay);
		z = longint'(az);
		roll = 0;
		pitch = 0;
		mag = 0;
		raw = 0;
		if (y != 0 || z != 0) begin
			a = z * VEC_ONE;
			b = y * VEC_ONE;
			base = 0;
			if (a < 0) begin
				a = -a;
				b = -b;
				base = (y >= 0) ? HALF_TURN : -HALF_TURN;
			end
			roll = base + cordic_vector(a, b, raw);
			mag = (raw * GAIN_FIX) >>> 30;
		end
		roll = limit_angle(roll, HALF_TURN);
		if (mag != 0 || x != 0) begin
			pitch = cordic_vector(mag, -x * VEC_ONE, raw);
		end
		pitch = limit_angle(pitch, QUARTER_TURN);
		if (!primed) begin
			roll_f = 26'(roll);
			pitch_f = 26'(pitch);
			primed = 1'b1;
		end else begin
			roll_f = 26'(smooth(longint'(roll_f), roll));
			pitch_f = 26'(smooth(longint'(pitch_f), pitch));
		end
		r.roll = 17'((longint'(roll_f) + 256) >>> 9);
		r.pitch = 16'((longint'(pitch_f) + 256) >>> 9);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tilt_t want;
		if (!arst_n) begin
			expected_tilts.delete();
			roll_f = '0;
			pitch_f = '0;
			primed = 1'b0;
			weight = atsm_pkg::ALPHA_RESET;
			mismatches <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_tilts.size() == 0) begin
					if (mismatches < 10) begin
						$display("Unexpected result transfer: roll %0d pitch %0d",
							$signed(tilt_x), $signed(tilt_y));
					end
					mismatches <= mismatches + 1;
				end else begin
					want = expected_tilts.pop_front();
					checked <= checked + 1;
					if (tilt_x !== want.roll || tilt_y !== want.pitch) begin
						if (mismatches < 10) begin
							$display({"Result %0d differs: expected roll %0d pitch %0d,",
								" got roll %0d pitch %0d"},
								checked, $signed(want.roll), $signed(want.pitch),
								$signed(tilt_x), $signed(tilt_y));
						end
						mismatches <= mismatches + 1;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				weight = (cfg_data > atsm_pkg::ALPHA_MAX) ? atsm_pkg::ALPHA_MAX : cfg_data;
			end
			if (in_valid && in_ready) begin
				expected_tilts.push_back(predict_tilt(accel_x, accel_y, accel_z));
			end
			pending <= expected_tilts.size();
		end
	end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt angle smoother testbench
// Drives accelerometer samples and smoothing weights into the tilt smoother
// and lets the checker compare every result. A directed part covers the zero
// vector, negative z on both sides of y, pitch at both poles and the field
// extremes under several weights. Random phases then use gravity-like, full
// range, tiny and corner samples with random gaps on both channels, one long
// receiver hold-off and one sender pause.
// ----------------------------------------------------------------------------
module tb;

	localparam int LIMIT = 400000;
	localparam logic [16:0] W_FULL = atsm_pkg::ALPHA_MAX;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic               out_valid;
	logic               out_ready;
	logic signed [16:0] tilt_x;
	logic signed [15:0] tilt_y;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [16:0]        cfg_data;

	int mismatches;
	int pending;
	int checked;
	int cycles = 0;
	int samples_sent = 0;
	int weight_writes = 0;
	int hold_reqs = 0;
	bit idle_on = 1'b1;

	accel_tilt_angle_smoother_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.accel_x   (accel_x),
		.accel_y   (accel_y),
		.accel_z   (accel_z),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.tilt_x    (tilt_x),
		.tilt_y    (tilt_y),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	tilt_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.accel_x    (accel_x),
		.accel_y    (accel_y),
		.accel_z    (accel_z),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.tilt_x     (tilt_x),
		.tilt_y     (tilt_y),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int stall_left;
		int hold_seen;
		stall_left = 0;
		hold_seen = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				stall_left = 400;
			end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 13);
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic signed [15:0] z);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		accel_x <= x;
		accel_y <= y;
		accel_z <= z;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		samples_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_weight(input logic [16:0] w);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= w;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		weight_writes++;
	endtask

	function automatic logic signed [15:0] corner_value();
		case ($urandom_range(0, 5))
			0:       return -16'sd32768;
			1:       return 16'sd32767;
			2:       return 16'sd0;
			3:       return 16'sd1;
			4:       return -16'sd1;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic make_sample(output logic signed [15:0] x, output logic signed [15:0] y,
			output logic signed [15:0] z);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				x = 16'($urandom_range(0, 32768) - 16384);
				y = 16'($urandom_range(0, 32768) - 16384);
				z = 16'($urandom_range(0, 32768) - 16384);
			end
			5, 6: begin
				x = 16'($urandom);
				y = 16'($urandom);
				z = 16'($urandom);
			end
			7: begin
				x = 16'($urandom_range(0, 6) - 3);
				y = 16'($urandom_range(0, 6) - 3);
				z = 16'($urandom_range(0, 6) - 3);
			end
			8: begin
				x = 16'($urandom);
				y = corner_value();
				z = corner_value();
			end
			default: begin
				x = corner_value();
				y = corner_value();
				z = corner_value();
			end
		endcase
	endtask

	function automatic logic [16:0] phase_weight(input int p);
		case (p)
			0:       return 17'd1;
			1:       return 17'd65535;
			2:       return 17'd65537;
			3:       return 17'd32768;
			4:       return 17'd131071;
			5:       return atsm_pkg::ALPHA_RESET;
			default: return 17'($urandom_range(0, 131071));
		endcase
	endfunction

	initial begin
		logic signed [15:0] rx;
		logic signed [15:0] ry;
		logic signed [15:0] rz;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		accel_x <= '0;
		accel_y <= '0;
		accel_z <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first sample loads the filter; the reset weight applies after it.
		send_sample(16'sd0, 16'sd0, 16'sd0);
		send_sample(16'sd0, 16'sd0, 16'sd16384);

		write_weight(W_FULL);
		send_sample(16'sd0, 16'sd0, -16'sd16384);
		send_sample(16'sd0, -16'sd1, -16'sd16384);
		send_sample(16'sd5, 16'sd1, -16'sd32768);
		send_sample(-16'sd32768, 16'sd0, 16'sd0);
		send_sample(16'sd32767, 16'sd0, 16'sd0);
		send_sample(16'sd0, 16'sd32767, 16'sd0);
		send_sample(16'sd0, -16'sd32768, 16'sd0);
		send_sample(-16'sd32768, -16'sd32768, -16'sd32768);
		send_sample(16'sd32767, 16'sd32767, 16'sd32767);
		send_sample(16'sd21845, -16'sd21846, 16'sd21845);
		send_sample(-16'sd21846, 16'sd21845, -16'sd21846);
		send_sample(16'sd1, 16'sd1, 16'sd1);
		send_sample(-16'sd1, -16'sd1, -16'sd1);

		// A zero weight freezes the filter.
		write_weight(17'd0);
		send_sample(16'sd32767, -16'sd32768, -16'sd100);
		send_sample(-16'sd300, 16'sd200, 16'sd16000);

		write_weight(17'd131071);
		send_sample(16'sd0, 16'sd16384, 16'sd16384);
		send_sample(-16'sd8000, -16'sd8000, -16'sd16000);

		for (int p = 0; p < 8; p++) begin
			write_weight(phase_weight(p));
			if (p == 7) begin
				idle_on <= 1'b0;
			end
			if (p == 3) begin
				hold_reqs <= hold_reqs + 1;
			end
			for (int i = 0; i < 50; i++) begin
				if (p == 5 && i == 25) begin
					settle();
				end
				make_sample(rx, ry, rz);
				send_sample(rx, ry, rz);
			end
		end

		settle();
		$display("Covered %0d samples under %0d weight settings, from zero through saturation.",
			samples_sent, weight_writes + 1);
		$display("Compared %0d results, %0d mismatched.", checked, mismatches);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
